// ===== design/ptsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsm_pkg
// Shared types and constants of the pitch-tracking sawtooth masker.
// ----------------------------------------------------------------------------
package ptsm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int LEVEL_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int LEN_W      = 7;
  localparam int TICK_W     = 16;
  localparam int RAMP_W     = 16;
  localparam int EST_W      = 24;
  localparam int PHASE_W    = 6;

  // Samples per block; the prescale phase restarts at each block boundary.
  localparam int BLOCK_LEN  = 1024;
  localparam int BLK_W      = $clog2(BLOCK_LEN);

  // Shared bit-serial divider: numerator width equals the number of steps.
  localparam int NUM_W      = 35;
  localparam int DIV_STEPS  = NUM_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int REM_W      = EST_W + 1;

  localparam logic [SAMPLE_W-1:0] THRESH_RST = 12'd2048;
  localparam logic [LEN_W-1:0]    AVG_RST    = 7'd15;
  localparam logic [LEN_W-1:0]    PRE_RST    = 7'd15;
  localparam logic [LEVEL_W-1:0]  FS_RST     = 12'd2048;
  localparam logic [EST_W-1:0]    EST_RST    = 24'd64000;  // 250.0 in Q16.8
  localparam logic [EST_W-1:0]    EST_MIN    = 24'd256;    // 1.0 in Q16.8
  localparam logic [LEN_W-1:0]    PRE_MAX    = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESH    = 2'd0,
    REG_AVG_LEN   = 2'd1,
    REG_PRESCALE  = 2'd2,
    REG_FULLSCALE = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_AVG_LOAD = 6'b000010,
    ST_DIV      = 6'b000100,
    ST_AVG_DONE = 6'b001000,
    ST_LVL_LOAD = 6'b010000,
    ST_LVL_DONE = 6'b100000
  } state_t;

endpackage

// ===== design/pitch_tracking_sawtooth_masker_top.sv =====
// ----------------------------------------------------------------------------
// pitch_tracking_sawtooth_masker_top
// Tracks the half period of a voice signal and emits a matching sawtooth.
// ----------------------------------------------------------------------------
// One sample is taken per transfer on the in_ channel and exactly one DAC
// level leaves per transfer on the out_ channel. Work on a sample is done by
// a single restoring divider that produces one quotient bit per cycle. A
// sample without a threshold crossing occupies the block from its transfer
// until the next sample can be taken (accept, load, 35 divide steps, finish,
// where finish waits until the output register is free). A sample with a
// crossing first runs the divider for the running-average update as well
// (load, 35 divide steps, finish). The next sample is taken as soon as the
// block is back in idle, even while the previous level still waits in the
// output register. Configuration writes are always taken (cfg_ready is tied
// high) and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module pitch_tracking_sawtooth_masker_top
  import ptsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_W-1:0]    out_level,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [SAMPLE_W-1:0] thresh_r;
  logic [LEN_W-1:0]    avg_len_r;
  logic [LEN_W-1:0]    prescale_r;
  logic [LEVEL_W-1:0]  fs_r;

  // Tracking state.
  logic [TICK_W-1:0]   tick_r,   tick_nxt;
  logic [RAMP_W-1:0]   ramp_r,   ramp_nxt;
  logic                rising_r, rising_nxt;
  logic [EST_W-1:0]    est_r,    est_nxt;
  logic [PHASE_W-1:0]  phase_r,  phase_nxt;
  logic [BLK_W-1:0]    blk_r,    blk_nxt;

  // Sequencer and divider.
  state_t              state_r,  state_nxt;
  logic                avg_op_r, avg_op_nxt;
  logic [NUM_W-1:0]    num_r,    num_nxt;
  logic [EST_W-1:0]    dvs_r,    dvs_nxt;
  logic [EST_W-1:0]    rem_r,    rem_nxt;
  logic [EST_W-1:0]    quo_r,    quo_nxt;
  logic                ovf_r,    ovf_nxt;
  logic [CNT_W-1:0]    cnt_r,    cnt_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]  out_level_r, out_level_nxt;

  // Effective register values after the documented remapping.
  logic [LEN_W-1:0]    n_eff;
  logic [LEN_W-1:0]    n_m1;
  logic [LEN_W-1:0]    p_eff;

  logic                in_xfer;
  logic                crossing;
  logic [30:0]         avg_prod;
  logic [31:0]         avg_num;
  logic [27:0]         lvl_prod;
  logic [REM_W-1:0]    rem_sh;
  logic                step_ge;
  logic [REM_W-1:0]    rem_sub;
  logic                lvl_clamp;
  logic                ramp_wrap;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign in_xfer   = in_valid && in_ready;

  assign n_eff = (avg_len_r == '0) ? LEN_W'(1) : avg_len_r;
  assign n_m1  = n_eff - LEN_W'(1);
  assign p_eff = (prescale_r == '0) ? LEN_W'(1) :
                 ((prescale_r > PRE_MAX) ? PRE_MAX : prescale_r);

  // A crossing counts only in the direction that is expected next.
  assign crossing = rising_r ? (in_sample <= thresh_r) : (in_sample > thresh_r);

  // Running average numerator: est*(N-1) + ticks in Q16.8.
  assign avg_prod = 31'(est_r) * 31'(n_m1);
  assign avg_num  = {1'b0, avg_prod} + {8'd0, tick_r, 8'd0};

  // Level numerator: ramp * full_scale * 128.
  assign lvl_prod = 28'(ramp_r) * 28'(fs_r);

  // One restoring division step per cycle.
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign step_ge = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // The quotient is clamped to full scale, including bits already shifted out.
  assign lvl_clamp = ovf_r || (quo_r[EST_W-1:LEVEL_W] != '0) ||
                     (quo_r[LEVEL_W-1:0] > fs_r);
  assign ramp_wrap = ({1'b0, ramp_r, 7'd0} >= est_r);

  always_comb begin
    state_nxt     = state_r;
    avg_op_nxt    = avg_op_r;
    num_nxt       = num_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    ovf_nxt       = ovf_r;
    cnt_nxt       = cnt_r;
    tick_nxt      = tick_r;
    ramp_nxt      = ramp_r;
    rising_nxt    = rising_r;
    est_nxt       = est_r;
    phase_nxt     = phase_r;
    blk_nxt       = blk_r;
    out_valid_nxt = out_valid_r;
    out_level_nxt = out_level_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // Tick and ramp counters advance first, both saturating; the tick counter only at prescale phase zero.
          if ((phase_r == '0) && (tick_r != '1)) begin
            tick_nxt = tick_r + TICK_W'(1);
          end
          if (ramp_r != '1) begin
            ramp_nxt = ramp_r + RAMP_W'(1);
          end
          // Prescale phase restarts at each block boundary.
          if (blk_r == BLK_W'(BLOCK_LEN - 1)) begin
            blk_nxt   = '0;
            phase_nxt = '0;
          end else begin
            blk_nxt = blk_r + BLK_W'(1);
            if (({1'b0, phase_r} + LEN_W'(1)) >= p_eff) begin
              phase_nxt = '0;
            end else begin
              phase_nxt = phase_r + PHASE_W'(1);
            end
          end
          state_nxt = crossing ? ST_AVG_LOAD : ST_LVL_LOAD;
        end
      end

      ST_AVG_LOAD: begin
        num_nxt    = {3'd0, avg_num};
        dvs_nxt    = {17'd0, n_eff};
        rem_nxt    = '0;
        quo_nxt    = '0;
        ovf_nxt    = 1'b0;
        cnt_nxt    = '0;
        avg_op_nxt = 1'b1;
        state_nxt  = ST_DIV;
      end

      ST_LVL_LOAD: begin
        num_nxt    = {lvl_prod, 7'd0};
        dvs_nxt    = est_r;
        rem_nxt    = '0;
        quo_nxt    = '0;
        ovf_nxt    = 1'b0;
        cnt_nxt    = '0;
        avg_op_nxt = 1'b0;
        state_nxt  = ST_DIV;
      end

      ST_DIV: begin
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        rem_nxt = step_ge ? rem_sub[EST_W-1:0] : rem_sh[EST_W-1:0];
        quo_nxt = {quo_r[EST_W-2:0], step_ge};
        ovf_nxt = ovf_r | quo_r[EST_W-1];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = avg_op_r ? ST_AVG_DONE : ST_LVL_DONE;
        end
      end

      ST_AVG_DONE: begin
        // The average never exceeds 24 bits, so only the floor of 1.0 applies.
        est_nxt    = (quo_r < EST_MIN) ? EST_MIN : quo_r;
        tick_nxt   = '0;
        rising_nxt = ~rising_r;
        state_nxt  = ST_LVL_LOAD;
      end

      ST_LVL_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = lvl_clamp ? fs_r : quo_r[LEVEL_W-1:0];
          if (ramp_wrap) begin
            ramp_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      avg_op_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tick_r      <= '0;
      ramp_r      <= '0;
      rising_r    <= 1'b1;
      est_r       <= EST_RST;
      phase_r     <= '0;
      blk_r       <= '0;
      cnt_r       <= '0;
      thresh_r    <= THRESH_RST;
      avg_len_r   <= AVG_RST;
      prescale_r  <= PRE_RST;
      fs_r        <= FS_RST;
    end else begin
      state_r     <= state_nxt;
      avg_op_r    <= avg_op_nxt;
      out_valid_r <= out_valid_nxt;
      tick_r      <= tick_nxt;
      ramp_r      <= ramp_nxt;
      rising_r    <= rising_nxt;
      est_r       <= est_nxt;
      phase_r     <= phase_nxt;
      blk_r       <= blk_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_THRESH:    thresh_r   <= cfg_data[SAMPLE_W-1:0];
          REG_AVG_LEN:   avg_len_r  <= cfg_data[LEN_W-1:0];
          REG_PRESCALE:  prescale_r <= cfg_data[LEN_W-1:0];
          REG_FULLSCALE: fs_r       <= cfg_data[LEVEL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    dvs_r       <= dvs_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    ovf_r       <= ovf_nxt;
    out_level_r <= out_level_nxt;
  end

endmodule
